>>> src/assert_macros.svh
// assertion helpers for the sampler checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every rising clock edge outside reset
`define CHK_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("check failed");

// next-cycle implication
`define CHK_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("check failed");

`endif

>>> src/cmb_pkg.sv
`timescale 1ns / 1ps
package cmb_pkg;
   localparam logic [2:0] FACE_NORTH  = 3'd0;
   localparam logic [2:0] FACE_SOUTH  = 3'd1;
   localparam logic [2:0] FACE_WEST   = 3'd2;
   localparam logic [2:0] FACE_LON0   = 3'd3;
   localparam logic [2:0] FACE_EAST   = 3'd4;
   localparam logic [2:0] FACE_LON180 = 3'd5;
   localparam logic       REQ_WRITE   = 1'b0;
   localparam logic       REQ_SAMPLE  = 1'b1;
endpackage

>>> src/cmb_div.sv
`timescale 1ns / 1ps
// pipelined restoring divider: q = num / den, one quotient bit per stage
module cmb_div
   import cmb_pkg::*;
#(
   parameter int NW = 50,
   parameter int DW = 34,
   parameter int TW = 8
) (
   input  logic          clock,
   input  logic          en,
   input  logic [NW-1:0] num,
   input  logic [DW-1:0] den,
   input  logic [TW-1:0] tag_in,
   output logic [NW-1:0] quo,
   output logic [TW-1:0] tag_out
);
   logic [DW:0]   rem_ff [NW+1];
   logic [NW-1:0] num_ff [NW+1];
   logic [NW-1:0] q_ff   [NW+1];
   logic [DW-1:0] den_ff [NW+1];
   logic [TW-1:0] tag_ff [NW+1];

   always_comb begin
      rem_ff[0] = '0;
      num_ff[0] = num;
      q_ff[0]   = '0;
      den_ff[0] = den;
      tag_ff[0] = tag_in;
   end

   // one bit per stage, msb first
   for (genvar g = 0; g < NW; g++) begin : g_st
      logic [DW:0] sh_in;
      logic [DW:0] rem_in;
      logic [NW-1:0] q_in;
      always_comb begin
         sh_in = {rem_ff[g][DW-1:0], num_ff[g][NW-1-g]};
         rem_in = sh_in;
         q_in = q_ff[g];
         if (sh_in >= {1'b0, den_ff[g]}) begin
            rem_in = sh_in - {1'b0, den_ff[g]};
            q_in[NW-1-g] = 1'b1;
         end
      end
      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[g+1] <= rem_in;
            num_ff[g+1] <= num_ff[g];
            q_ff[g+1]   <= q_in;
            den_ff[g+1] <= den_ff[g];
            tag_ff[g+1] <= tag_ff[g];
         end
      end
   end

   assign quo = q_ff[NW];
   assign tag_out = tag_ff[NW];
endmodule

>>> src/cube_map_bilinear_sampler_top.sv
`timescale 1ns / 1ps
// channel | ports                          | word
// req     | req_valid/req_stall            | write texel or sample direction
// rsp     | rsp_valid/rsp_stall            | face_hit, height_sample
// csr     | csr_write_en/csr_write_data    | face_side
// one word per cycle in while rsp is not stalled; a sample result passes stage 1, the
// divider pipe (33+FRAC_BITS stages) and stages 2 to 5 before it shows on rsp
// texel writes ride the same pipe and land in order at the read stage
// a stall on rsp freezes the whole pipe; req_stall follows rsp_stall while rsp_valid is high
// reset clears valid bits and sets face_side to 256; the texel store is not cleared
module cube_map_bilinear_sampler_top
   import cmb_pkg::*;
#(
   parameter int MAX_SIDE  = 256,
   parameter int FRAC_BITS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_type,
   input  logic [2:0]         req_write_face,
   input  logic [7:0]         req_write_col,
   input  logic [7:0]         req_write_row,
   input  logic signed [15:0] req_write_value,
   input  logic signed [31:0] req_dir_x,
   input  logic signed [31:0] req_dir_y,
   input  logic signed [31:0] req_dir_z,
   input  logic               csr_write_en,
   input  logic [8:0]         csr_write_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [2:0]         rsp_face_hit,
   output logic signed [31:0] rsp_height_sample
);
   localparam int SB = $clog2(MAX_SIDE);
   localparam int HS = (MAX_SIDE + 1) / 2;
   localparam int BD = 6 * HS * HS;
   localparam int BA = $clog2(BD);
   localparam int NW = 33 + FRAC_BITS;
   localparam int DW = 34;
   localparam int TW_U = 35 + 3 + 1;
   localparam int TW_V = 1;
   localparam int PW = FRAC_BITS + SB + 1;

   logic en;
   assign en = !(rsp_valid && rsp_stall);
   assign req_stall = !en;

   // side register
   logic [8:0] side_ff;
   always_ff @(posedge clock) begin
      if (reset) side_ff <= 9'd256;
      else if (csr_write_en) side_ff <= csr_write_data;
   end
   logic [SB:0] side_u;
   always_comb begin
      if (side_ff < 9'd2) side_u = (SB+1)'(2);
      else if ({23'd0, side_ff} > 32'(MAX_SIDE)) side_u = (SB+1)'(MAX_SIDE);
      else side_u = (SB+1)'(side_ff);
   end

   // write words that land inside the store
   logic wr_ok;
   always_comb begin
      wr_ok = req_valid && req_type == REQ_WRITE && req_write_face <= FACE_LON180
              && {24'd0, req_write_col} < 32'(MAX_SIDE)
              && {24'd0, req_write_row} < 32'(MAX_SIDE);
   end

   // stage 1: magnitudes and face pick
   logic s1_v_ff, s1_wv_ff;
   logic [34:0] s1_wr_ff;
   logic [2:0] s1_face_ff;
   logic signed [33:0] s1_nu_ff, s1_nv_ff;
   logic [33:0] s1_d_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
         s1_wv_ff <= 1'b0;
      end else if (en) begin
         s1_v_ff <= req_valid && req_type == REQ_SAMPLE;
         s1_wv_ff <= wr_ok;
      end
   end
   always_ff @(posedge clock) begin
      logic signed [33:0] x, y, z;
      logic [33:0] ax, ay, az;
      if (en) begin
         s1_wr_ff <= {req_write_face, req_write_row, req_write_col, req_write_value};
         x = 34'(req_dir_x); y = 34'(req_dir_y); z = 34'(req_dir_z);
         ax = x[33] ? 34'(-x) : x;
         ay = y[33] ? 34'(-y) : y;
         az = z[33] ? 34'(-z) : z;
         if (ax >= ay && ax >= az) begin
            s1_d_ff <= ax; s1_nv_ff <= z;
            if (x > 0) begin s1_face_ff <= FACE_LON0; s1_nu_ff <= y; end
            else begin s1_face_ff <= FACE_LON180; s1_nu_ff <= -y; end
         end else if (ay >= az) begin
            s1_d_ff <= ay; s1_nv_ff <= z;
            if (y > 0) begin s1_face_ff <= FACE_EAST; s1_nu_ff <= -x; end
            else begin s1_face_ff <= FACE_WEST; s1_nu_ff <= x; end
         end else begin
            s1_d_ff <= az; s1_nu_ff <= x;
            if (z > 0) begin s1_face_ff <= FACE_NORTH; s1_nv_ff <= y; end
            else begin s1_face_ff <= FACE_SOUTH; s1_nv_ff <= -y; end
         end
      end
   end

   // numerators and divisor for both coordinates
   logic [NW-1:0] num_u, num_v;
   logic [DW-1:0] den;
   logic zero_d;
   always_comb begin
      zero_d = (s1_d_ff == '0);
      num_u = NW'(34'(s1_nu_ff + $signed(s1_d_ff))) << FRAC_BITS;
      num_v = NW'(34'(s1_nv_ff + $signed(s1_d_ff))) << FRAC_BITS;
      den = zero_d ? DW'(1) : DW'({s1_d_ff[32:0], 1'b0});
   end

   // write payload rides the u divider tag
   logic [NW-1:0] qu, qv;
   logic [TW_U-1:0] tu;
   logic [TW_V-1:0] tv;
   cmb_div #(.NW(NW), .DW(DW), .TW(TW_U)) u_div_u (
      .clock(clock), .en(en), .num(num_u), .den(den),
      .tag_in({s1_wr_ff, s1_face_ff, zero_d}), .quo(qu), .tag_out(tu));
   cmb_div #(.NW(NW), .DW(DW), .TW(TW_V)) u_div_v (
      .clock(clock), .en(en), .num(num_v), .den(den),
      .tag_in(1'b0), .quo(qv), .tag_out(tv));

   // valid bits tracked separately so reset clears them: write, sample
   logic [1:0] dv_ff [NW+1];
   always_comb dv_ff[0] = {s1_wv_ff, s1_v_ff};
   for (genvar g = 0; g < NW; g++) begin : g_v
      always_ff @(posedge clock) begin
         if (reset) dv_ff[g+1] <= 2'b00;
         else if (en) dv_ff[g+1] <= dv_ff[g];
      end
   end

   // stage 2: saturate, scale by side-1
   logic s2_v_ff, s2_wv_ff;
   logic [34:0] s2_wr_ff;
   logic [2:0] s2_face_ff;
   logic [PW-1:0] s2_px_ff, s2_py_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_v_ff <= 1'b0;
         s2_wv_ff <= 1'b0;
      end else if (en) begin
         s2_v_ff <= dv_ff[NW][0];
         s2_wv_ff <= dv_ff[NW][1];
      end
   end
   always_ff @(posedge clock) begin
      logic [FRAC_BITS:0] u, v;
      if (en) begin
         if (tu[0]) begin
            u = (FRAC_BITS+1)'(1) << (FRAC_BITS-1); v = u;
         end else begin
            u = (qu > NW'(1) << FRAC_BITS) ? (FRAC_BITS+1)'(1) << FRAC_BITS
                : qu[FRAC_BITS:0];
            v = (qv > NW'(1) << FRAC_BITS) ? (FRAC_BITS+1)'(1) << FRAC_BITS
                : qv[FRAC_BITS:0];
         end
         s2_face_ff <= tu[3:1];
         s2_wr_ff <= tu[TW_U-1:4];
         s2_px_ff <= PW'(u) * PW'(side_u - 1'b1);
         s2_py_ff <= PW'(v) * PW'(side_u - 1'b1);
      end
   end
   logic unused_tv;
   assign unused_tv = ^tv;

   // stage 3: neighbour addresses, banked reads and in-order texel writes
   // four banks by row and column parity; away from a clamped edge each bank serves one neighbour
   logic s3_v_ff, s4_v_ff;
   logic [2:0] s3_face_ff, s4_face_ff;
   logic [FRAC_BITS-1:0] s3_fx_ff, s3_fy_ff, s4_fx_ff;
   logic [3:0] s3_par_ff;
   logic [15:0] t_ff [4];
   always_ff @(posedge clock) begin
      if (reset) begin s3_v_ff <= 1'b0; s4_v_ff <= 1'b0; end
      else if (en) begin s3_v_ff <= s2_v_ff; s4_v_ff <= s3_v_ff; end
   end
   logic [SB:0] ix, iy, ix1, iy1, smax;
   logic [BA-1:0] ra [4];
   logic [1:0] wr_bank;
   logic [BA-1:0] wr_addr;
   always_comb begin
      logic [SB:0] cb, rb;
      smax = side_u - 1'b1;
      ix = (SB+1)'(s2_px_ff >> FRAC_BITS);
      iy = (SB+1)'(s2_py_ff >> FRAC_BITS);
      ix1 = (ix + 1'b1 > smax) ? smax : ix + 1'b1;
      iy1 = (iy + 1'b1 > smax) ? smax : iy + 1'b1;
      for (int b = 0; b < 4; b++) begin
         cb = (ix[0] == 1'(b)) ? ix : ix1;
         rb = (iy[0] == 1'(b >> 1)) ? iy : iy1;
         ra[b] = BA'(32'(s2_face_ff) * 32'(HS * HS) + 32'(rb >> 1) * 32'(HS)
                 + 32'(cb >> 1));
      end
      wr_bank = {s2_wr_ff[24], s2_wr_ff[16]};
      wr_addr = BA'(32'(s2_wr_ff[34:32]) * 32'(HS * HS) + 32'(s2_wr_ff[31:25]) * 32'(HS)
                + 32'(s2_wr_ff[23:17]));
   end
   for (genvar b = 0; b < 4; b++) begin : g_bank
      logic [15:0] mem [BD];
      always_ff @(posedge clock) begin
         if (en) begin
            if (s2_wv_ff && wr_bank == 2'(b)) mem[wr_addr] <= s2_wr_ff[15:0];
            t_ff[b] <= mem[ra[b]];
         end
      end
   end
   always_ff @(posedge clock) begin
      if (en) begin
         s3_face_ff <= s2_face_ff;
         s3_fx_ff <= s2_px_ff[FRAC_BITS-1:0];
         s3_fy_ff <= s2_py_ff[FRAC_BITS-1:0];
         s3_par_ff <= {iy1[0], iy[0], ix1[0], ix[0]};
      end
   end

   // stage 4: pick neighbours from banks, vertical blend
   localparam int BW = 17 + FRAC_BITS + 1;
   logic [BW-1:0] left_ff, right_ff;
   always_ff @(posedge clock) begin
      logic [BW-1:0] fy, ify;
      logic [15:0] tl, tr, bl, br;
      if (en) begin
         tl = t_ff[{s3_par_ff[2], s3_par_ff[0]}];
         tr = t_ff[{s3_par_ff[2], s3_par_ff[1]}];
         bl = t_ff[{s3_par_ff[3], s3_par_ff[0]}];
         br = t_ff[{s3_par_ff[3], s3_par_ff[1]}];
         fy = BW'(s3_fy_ff);
         ify = (BW'(1) << FRAC_BITS) - fy;
         left_ff  <= BW'({~tl[15], tl[14:0]}) * ify
                     + BW'({~bl[15], bl[14:0]}) * fy;
         right_ff <= BW'({~tr[15], tr[14:0]}) * ify
                     + BW'({~br[15], br[14:0]}) * fy;
         s4_face_ff <= s3_face_ff;
         s4_fx_ff <= s3_fx_ff;
      end
   end

   // stage 5: horizontal blend and output register
   localparam int SW = BW + FRAC_BITS + 1;
   always_ff @(posedge clock) begin
      if (reset) rsp_valid <= 1'b0;
      else if (en) rsp_valid <= s4_v_ff;
   end
   always_ff @(posedge clock) begin
      logic [SW-1:0] fx, ifx, sum, q;
      if (en) begin
         fx = SW'(s4_fx_ff);
         ifx = (SW'(1) << FRAC_BITS) - fx;
         sum = SW'(left_ff) * ifx + SW'(right_ff) * fx;
         q = sum >> (2 * FRAC_BITS - 16);
         rsp_height_sample <= 32'(q - (SW'(32768) << 16));
         rsp_face_hit <= s4_face_ff;
      end
   end
endmodule

>>> src/cmb_checker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module cmb_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_stall,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [2:0] rsp_face_hit
);
   `CHK_IMPLY(a_face_ok, clock, reset, rsp_valid, rsp_face_hit <= 3'd5)
   `CHK_IMPLY(a_back, clock, reset, rsp_valid && rsp_stall, req_stall)
   `CHK_NEXT(a_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid)
   `CHK_IMPLY(a_free, clock, reset, !rsp_valid, !req_stall)
endmodule

bind cube_map_bilinear_sampler_top cmb_checker u_chk (
   .clock(clock), .reset(reset), .req_stall(req_stall), .rsp_valid(rsp_valid),
   .rsp_stall(rsp_stall), .rsp_face_hit(rsp_face_hit));
